// File: hw/rtl/acss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acss_pkg: shared types and constants of the ADC channel scan sequencer
// Channel count, field widths, mux code mapping and controller types.
// ----------------------------------------------------------------------------
package acss_pkg;

  localparam int NUM_CHANNELS = 11;
  localparam int SAMPLE_BITS  = 10;
  localparam int DIRECT_LIMIT = 8;
  localparam int CH_W         = 4;
  localparam int MUX_W        = 4;
  localparam int MASK_W       = 11;

  localparam logic [MUX_W-1:0] MUX_OFFSET = MUX_W'(5);

  typedef logic [CH_W-1:0]        chan_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MASK_W-1:0]      mask_t;
  typedef logic [MUX_W-1:0]       mux_t;

  typedef enum logic {
    FUNC_CONVERT = 1'b0,
    FUNC_READ    = 1'b1
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } acss_cmd_t;

  // Map a logical channel to its multiplexer select
  function automatic mux_t mux_of(chan_t ch);
    mux_t code;
    if (int'(ch) <= DIRECT_LIMIT) begin
      code = MUX_W'(ch);
    end else begin
      code = MUX_W'(ch) + MUX_OFFSET;
    end
    return code;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/acss_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acss_in_if: input channel of the scan sequencer
// Conversion-done and read transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface acss_in_if import acss_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    func;
  sample_t sample;
  chan_t   read_channel;

  modport source (output valid, output func, output sample, output read_channel,
                  input ready);
  modport sink   (input valid, input func, input sample, input read_channel,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/acss_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acss_out_if: result channel of the scan sequencer
// One result transaction per accepted input transaction.
// ----------------------------------------------------------------------------
interface acss_out_if import acss_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t read_value;
  mux_t    mux_code;
  chan_t   scan_channel;
  logic    none_enabled;

  modport source (output valid, output read_value, output mux_code,
                  output scan_channel, output none_enabled, input ready);
  modport sink   (input valid, input read_value, input mux_code,
                  input scan_channel, input none_enabled, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/adc_channel_scan_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer: round-robin ADC channel scan sequencer
// Stores conversion results per channel and selects the next channel.
// ----------------------------------------------------------------------------
// Each input transaction is first accepted and captured, then executed: the
// sample is stored or the table read, and the result register is loaded. The
// next transaction is accepted while a result waits on the output, and its
// execution waits until that result is taken. The round-robin search over
// the eleven enable bits resolves in the execute cycle. The enable mask is
// written through cfg_we/cfg_wdata and resets to channel 0 only; with an
// empty mask the channel stays put and none_enabled is raised.
module adc_channel_scan_sequencer import acss_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  acss_in_if.sink     in_ch,
  acss_out_if.source  out_ch,
  input  wire logic   cfg_we,
  input  wire mask_t  cfg_wdata
);

  acss_cmd_t cmd;

  // Sequence transactions
  acss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Hold table, channel and results
  acss_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_ch.func),
    .in_sample        (in_ch.sample),
    .in_read_channel  (in_ch.read_channel),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_read_value   (out_ch.read_value),
    .out_mux_code     (out_ch.mux_code),
    .out_scan_channel (out_ch.scan_channel),
    .out_none_enabled (out_ch.none_enabled)
  );

endmodule
`default_nettype wire

// File: hw/rtl/acss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acss_ctrl: scan sequencer controller
// Two-state machine sequencing capture and execution, and result valid.
// ----------------------------------------------------------------------------
module acss_ctrl import acss_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output acss_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: hw/rtl/acss_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acss_dp: scan sequencer datapath
// Result table, current channel, enable mask, round-robin search, outputs.
// ----------------------------------------------------------------------------
module acss_dp import acss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire acss_cmd_t cmd,
  input  wire logic      in_func,
  input  wire sample_t   in_sample,
  input  wire chan_t     in_read_channel,
  input  wire logic      cfg_we,
  input  wire mask_t     cfg_wdata,
  output sample_t        out_read_value,
  output mux_t           out_mux_code,
  output chan_t          out_scan_channel,
  output logic           out_none_enabled
);

  sample_t table_r [NUM_CHANNELS];
  chan_t   cur_r, cur_nxt;
  mask_t   mask_r;
  logic    func_r;
  sample_t sample_r;
  chan_t   rch_r;
  sample_t rv_r, rv_nxt;
  mux_t    mux_r;
  chan_t   scan_r;
  logic    none_r;
  logic    [NUM_CHANNELS-1:0] en_bits;
  logic    empty;

  assign en_bits = mask_r[NUM_CHANNELS-1:0];
  assign empty   = (en_bits == '0);

  // Find the next enabled channel after the current one, wrapping round
  always_comb begin
    logic found;
    int   c;
    found   = 1'b0;
    cur_nxt = cur_r;
    for (int i = 1; i <= NUM_CHANNELS; i++) begin
      c = int'(cur_r) + i;
      if (c >= NUM_CHANNELS) begin
        c = c - NUM_CHANNELS;
      end
      if (!found && en_bits[c[CH_W-1:0]]) begin
        found   = 1'b1;
        cur_nxt = CH_W'(c);
      end
    end
  end

  // Select the stored result of the requested channel
  always_comb begin
    rv_nxt = '0;
    if (func_r == FUNC_READ && int'(rch_r) < NUM_CHANNELS) begin
      rv_nxt = table_r[rch_r];
    end
  end

  // Control state: table, channel and mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        table_r[i] <= '0;
      end
      cur_r  <= '0;
      mask_r <= MASK_W'(1);
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (cmd.execute && func_r == FUNC_CONVERT) begin
        if (int'(cur_r) < NUM_CHANNELS) begin
          table_r[cur_r] <= sample_r;
        end
        cur_r <= cur_nxt;
      end
    end
  end

  // Capture the transaction and load the result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      sample_r <= in_sample;
      rch_r    <= in_read_channel;
    end
    if (cmd.execute) begin
      rv_r   <= rv_nxt;
      scan_r <= (func_r == FUNC_CONVERT) ? cur_nxt : cur_r;
      mux_r  <= mux_of((func_r == FUNC_CONVERT) ? cur_nxt : cur_r);
      none_r <= empty;
    end
  end

  assign out_read_value   = rv_r;
  assign out_mux_code     = mux_r;
  assign out_scan_channel = scan_r;
  assign out_none_enabled = none_r;

endmodule
`default_nettype wire

// File: tb/tb_adc_channel_scan_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_channel_scan_sequencer: self-checking bench of the scan sequencer
// Drives conversion and read transactions through a queue-fed driver, keeps
// a scoreboard of predicted results from its own scan model and checks each
// result transaction field by field under varied enable masks and flow control.
// ----------------------------------------------------------------------------
module tb_adc_channel_scan_sequencer;
  import acss_pkg::*;

  localparam int          CLK_HALF       = 6;
  localparam int          RESET_CYCLES   = 9;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          BATCH_ITEMS    = 32;
  localparam int          BURST_ITEMS    = 40;
  localparam mask_t       MASK_ALL       = '1;
  localparam mask_t       MASK_NONE      = '0;
  localparam mask_t       MASK_RESET     = MASK_W'(1);
  localparam sample_t     SAMPLE_MAX     = '1;
  localparam sample_t     SAMPLE_MIN     = '0;
  localparam chan_t       CHAN_MAX       = '1;

  typedef struct {
    func_t   func;
    sample_t sample;
    chan_t   read_channel;
  } scan_item_t;

  typedef struct {
    sample_t read_value;
    mux_t    mux_code;
    chan_t   scan_channel;
    logic    none_enabled;
  } scan_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  mask_t cfg_wdata;

  acss_in_if  in_ch ();
  acss_out_if out_ch ();

  adc_channel_scan_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Scan model state
  sample_t sample_store [NUM_CHANNELS];
  chan_t   scan_chan;
  mask_t   enable_mask;

  scan_item_t   pending_items [$];
  scan_result_t expected_results [$];

  int n_queued = 0;
  int n_accepted = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit failed = 0;
  logic in_taken = 1'b0;

  scan_item_t   drive_item;
  scan_item_t   seen_item;
  scan_result_t want;

  // Predict the result of one transaction and update the scan state
  function automatic scan_result_t predict_scan(input scan_item_t it);
    scan_result_t r;
    chan_t        ch;
    bit           found;
    int           n;
    r.read_value = '0;
    if (it.func == FUNC_CONVERT) begin
      if (int'(scan_chan) < NUM_CHANNELS) sample_store[scan_chan] = it.sample;
      if (enable_mask != MASK_NONE) begin
        ch = scan_chan;
        found = 1'b0;
        for (n = 0; n < NUM_CHANNELS; n++) begin
          if (!found) begin
            ch = (int'(ch) + 1 >= NUM_CHANNELS) ? '0 : ch + 1'b1;
            if (enable_mask[ch]) begin
              scan_chan = ch;
              found = 1'b1;
            end
          end
        end
      end
    end else begin
      if (int'(it.read_channel) < NUM_CHANNELS) r.read_value = sample_store[it.read_channel];
    end
    // Upper channels skip the gap in the multiplexer, wrapping at four bits
    if (int'(scan_chan) <= DIRECT_LIMIT) r.mux_code = mux_t'(scan_chan);
    else r.mux_code = mux_t'(scan_chan) + MUX_OFFSET;
    r.scan_channel = scan_chan;
    r.none_enabled = (enable_mask == MASK_NONE);
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Driver: present queued items, idling at random between transactions
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = pending_items.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.func         <= drive_item.func;
        in_ch.sample       <= drive_item.sample;
        in_ch.read_channel <= drive_item.read_channel;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted inputs, check results, watch for a hang
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, out_ch.read_value);
          failed = 1'b1;
        end
        if (out_ch.mux_code !== want.mux_code) begin
          $error("mux_code: expected %0d, actual %0d", want.mux_code, out_ch.mux_code);
          failed = 1'b1;
        end
        if (out_ch.scan_channel !== want.scan_channel) begin
          $error("scan_channel: expected %0d, actual %0d",
                 want.scan_channel, out_ch.scan_channel);
          failed = 1'b1;
        end
        if (out_ch.none_enabled !== want.none_enabled) begin
          $error("none_enabled: expected %0d, actual %0d",
                 want.none_enabled, out_ch.none_enabled);
          failed = 1'b1;
        end
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      seen_item.func         = func_t'(in_ch.func);
      seen_item.sample       = in_ch.sample;
      seen_item.read_channel = in_ch.read_channel;
      expected_results.push_back(predict_scan(seen_item));
      n_accepted <= n_accepted + 1;
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_item(input func_t f, input sample_t s, input chan_t ch);
    scan_item_t it;
    it.func = f;
    it.sample = s;
    it.read_channel = ch;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Wait until every transaction is accepted and every result has arrived
  task automatic drain();
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the enable mask while the block is idle
  task automatic write_mask(input mask_t m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    enable_mask = m;
    @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    sample_t s;
    chan_t   ch;
    repeat (count) begin
      if ($urandom_range(9) == 0) s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      else s = sample_t'($urandom);
      // Mostly valid channels, some out of range
      if ($urandom_range(4) == 0) ch = chan_t'($urandom_range(15));
      else ch = chan_t'($urandom_range(NUM_CHANNELS - 1));
      queue_item(($urandom_range(99) < 70) ? FUNC_CONVERT : FUNC_READ, s, ch);
    end
  endtask

  function automatic mask_t pick_mask();
    case ($urandom_range(6))
      0: pick_mask = MASK_ALL;
      1: pick_mask = MASK_NONE;
      2: pick_mask = MASK_W'(1) << $urandom_range(NUM_CHANNELS - 1);
      3: pick_mask = mask_t'($urandom) & mask_t'($urandom);
      default: pick_mask = mask_t'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int n;
    int p;
    int sub;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_CONVERT;
    in_ch.sample       = '0;
    in_ch.read_channel = '0;
    out_ch.ready       = 1'b0;
    for (n = 0; n < NUM_CHANNELS; n++) sample_store[n] = '0;
    scan_chan   = '0;
    enable_mask = MASK_RESET;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Only the current channel enabled after reset; reads in and out of range
    queue_item(FUNC_CONVERT, SAMPLE_MAX, '0);
    queue_item(FUNC_READ, SAMPLE_MIN, '0);
    queue_item(FUNC_READ, SAMPLE_MAX, CHAN_MAX);
    queue_item(FUNC_READ, SAMPLE_MIN, chan_t'(NUM_CHANNELS));
    drain();

    // Walk every channel with wrap, covering the mux code offset
    write_mask(MASK_ALL);
    for (n = 0; n < NUM_CHANNELS; n++) queue_item(FUNC_CONVERT, sample_t'(10'h2AA ^ n), '0);
    queue_item(FUNC_READ, SAMPLE_MIN, chan_t'(NUM_CHANNELS - 1));
    queue_item(FUNC_READ, SAMPLE_MIN, chan_t'(NUM_CHANNELS - 2));
    drain();

    // Empty mask: store but hold the channel
    write_mask(MASK_NONE);
    queue_item(FUNC_CONVERT, sample_t'(10'h0AB), '0);
    queue_item(FUNC_READ, SAMPLE_MIN, '0);
    drain();

    // Disable the current channel between conversions
    write_mask(MASK_ALL);
    repeat (3) queue_item(FUNC_CONVERT, sample_t'($urandom), '0);
    drain();
    write_mask(MASK_RESET);
    queue_item(FUNC_CONVERT, sample_t'(10'h155), '0);
    queue_item(FUNC_READ, SAMPLE_MIN, chan_t'(3));
    drain();

    // Random phases under different flow control
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (sub = 0; sub < 4; sub++) begin
        write_mask(pick_mask());
        if (p == 0 && sub == 0) begin
          // Hold off the receiver so the block fills and stalls its input
          hold_req++;
          queue_random(BURST_ITEMS);
          drain();
        end
        queue_random(BATCH_ITEMS);
        drain();
      end
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
